FILE: rtl/i2crts_pkg.sv
// types and codes shared by the i2c register transfer sequencer
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package i2crts_pkg;

	typedef enum logic [1:0] {
		REQ_WRITE    = 2'd0,
		REQ_READ     = 2'd1,
		REQ_EVENT    = 2'd2,
		REQ_DMA_DONE = 2'd3
	} req_type_t;

	typedef enum logic [2:0] {
		ACT_NONE   = 3'd0,
		ACT_START  = 3'd1,
		ACT_ADDR   = 3'd2,
		ACT_DATA   = 3'd3,
		ACT_STOP   = 3'd4,
		ACT_TX_DMA = 3'd5,
		ACT_RX_DMA = 3'd6
	} bus_action_t;

	typedef enum logic [8:0] {
		PH_IDLE      = 9'b000000001,
		PH_DEV_ADDR  = 9'b000000010,
		PH_REG_ADDR  = 9'b000000100,
		PH_DATA_ONLY = 9'b000001000,
		PH_REG_DATA  = 9'b000010000,
		PH_STOP      = 9'b000100000,
		PH_RESTART   = 9'b001000000,
		PH_READ_ADDR = 9'b010000000,
		PH_RX_DMA    = 9'b100000000
	} phase_t;

	localparam int unsigned ADDR_BYTES_W = 3;
	localparam int unsigned REG_ADDR_W   = 32;
	localparam int unsigned LENGTH_W     = 16;

	typedef struct packed {
		req_type_t                 req_type;
		logic [7:0]                device_address;
		logic [REG_ADDR_W-1:0]     register_address;
		logic [ADDR_BYTES_W-1:0]   register_address_bytes;
		logic [LENGTH_W-1:0]       transfer_length;
		logic [7:0]                single_data_byte;
		logic                      start_sent;
		logic                      address_acked;
		logic                      tx_empty;
		logic                      byte_finished;
	} item_t;

	typedef struct packed {
		logic                 request_status;
		bus_action_t          bus_action;
		logic [7:0]           bus_byte;
		logic [LENGTH_W-1:0]  dma_count;
		logic                 busy_now;
	} result_t;

endpackage

`default_nettype wire

FILE: rtl/i2crts_req_if.sv
// request and bus event channel: valid/ready plus the input fields
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none

interface i2crts_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  req_type;
	logic [7:0]  device_address;
	logic [31:0] register_address;
	logic [2:0]  register_address_bytes;
	logic [15:0] transfer_length;
	logic [7:0]  single_data_byte;
	logic        start_sent;
	logic        address_acked;
	logic        tx_empty;
	logic        byte_finished;

	modport source (
		output valid, req_type, device_address, register_address,
			register_address_bytes, transfer_length, single_data_byte,
			start_sent, address_acked, tx_empty, byte_finished,
		input ready
	);

	modport sink (
		input valid, req_type, device_address, register_address,
			register_address_bytes, transfer_length, single_data_byte,
			start_sent, address_acked, tx_empty, byte_finished,
		output ready
	);
endinterface

`default_nettype wire

FILE: rtl/i2crts_rsp_if.sv
// result channel: valid/ready plus the bus action fields
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none

interface i2crts_rsp_if;
	logic        valid;
	logic        ready;
	logic        request_status;
	logic [2:0]  bus_action;
	logic [7:0]  bus_byte;
	logic [15:0] dma_count;
	logic        busy_now;

	modport source (
		output valid, request_status, bus_action, bus_byte, dma_count, busy_now,
		input ready
	);

	modport sink (
		input valid, request_status, bus_action, bus_byte, dma_count, busy_now,
		output ready
	);
endinterface

`default_nettype wire

FILE: rtl/i2c_register_transfer_sequencer_unit.sv
// top level of the i2c register transfer sequencer: input register,
// sequencer core and result register; depends on i2crts_pkg, the two
// channel interfaces and i2crts_seq_core
//
//   port  | dir | carries
//   ------+-----+-------------------------------------------------
//   req   | in  | write/read request, bus event or dma done, one per transaction
//   rsp   | out | request status, next bus action, byte, dma count, busy
//
// an accepted transaction passes the input register and then the result register
// before its result shows on rsp; one transaction per cycle is accepted while rsp
// is not stalled, as the core updates its state with each transaction it takes.
// arst_n clears the sequencer state and both stage valids.
// a stalled rsp holds its result; req keeps taking one more transaction
// into the input register and then drops ready until rsp moves.
`timescale 1ns / 1ps
`default_nettype none

module i2c_register_transfer_sequencer_unit #(
	parameter int MaxRegBytes = 4
) (
	input wire logic    clk,
	input wire logic    arst_n,
	i2crts_req_if.sink  req,
	i2crts_rsp_if.source rsp
);

	i2crts_pkg::item_t   item_in;
	i2crts_pkg::item_t   item_s1;
	logic                valid_s1;
	i2crts_pkg::result_t result_comb;
	i2crts_pkg::result_t rsp_q;
	logic                rsp_valid_q;
	logic                advance;
	logic                in_fire;

	assign item_in.req_type               = i2crts_pkg::req_type_t'(req.req_type);
	assign item_in.device_address         = req.device_address;
	assign item_in.register_address       = req.register_address;
	assign item_in.register_address_bytes = req.register_address_bytes;
	assign item_in.transfer_length        = req.transfer_length;
	assign item_in.single_data_byte       = req.single_data_byte;
	assign item_in.start_sent             = req.start_sent;
	assign item_in.address_acked          = req.address_acked;
	assign item_in.tx_empty               = req.tx_empty;
	assign item_in.byte_finished          = req.byte_finished;

	// the core commits a transaction only when its result has a place to go
	assign advance   = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || advance;
	assign in_fire   = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			item_s1 <= item_in;
		end
	end

	i2crts_seq_core #(
		.MaxRegBytes(MaxRegBytes)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.advance(advance),
		.item   (item_s1),
		.result (result_comb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_q <= result_comb;
		end
	end

	assign rsp.valid          = rsp_valid_q;
	assign rsp.request_status = rsp_q.request_status;
	assign rsp.bus_action     = rsp_q.bus_action;
	assign rsp.bus_byte       = rsp_q.bus_byte;
	assign rsp.dma_count      = rsp_q.dma_count;
	assign rsp.busy_now       = rsp_q.busy_now;

endmodule

`default_nettype wire

FILE: rtl/i2crts_seq_core.sv
// transaction state and next-action logic of the sequencer
// depends on i2crts_pkg
`timescale 1ns / 1ps
`default_nettype none

module i2crts_seq_core #(
	parameter int MaxRegBytes = 4
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              advance,
	input  wire i2crts_pkg::item_t item,
	output i2crts_pkg::result_t    result
);

	// the byte count field tops out at 7, so larger limits are clipped to 7
	localparam int SatLimit = (MaxRegBytes > 7) ? 7 : MaxRegBytes;
	localparam logic [i2crts_pkg::ADDR_BYTES_W-1:0] MaxCnt =
		i2crts_pkg::ADDR_BYTES_W'(SatLimit);

	i2crts_pkg::phase_t                      phase_q, phase_d;
	logic [7:0]                              target_q, target_d;
	logic [i2crts_pkg::REG_ADDR_W-1:0]       reg_held_q, reg_held_d;
	logic [i2crts_pkg::ADDR_BYTES_W-1:0]     reg_left_q, reg_left_d;
	logic [i2crts_pkg::ADDR_BYTES_W-1:0]     reg_count_q, reg_count_d;
	logic                                    is_read_q, is_read_d;
	logic [i2crts_pkg::LENGTH_W-1:0]         length_q, length_d;
	logic [7:0]                              data_byte_q, data_byte_d;
	logic                                    dma_run_q, dma_run_d;

	logic                                    busy;
	logic [i2crts_pkg::ADDR_BYTES_W-1:0]     req_cnt;
	logic [i2crts_pkg::ADDR_BYTES_W-1:0]     left_dec;
	logic [7:0]                              reg_byte;
	logic [7:0]                              addr_wr;
	logic [7:0]                              addr_rd;

	// write data dispatch: stop, one byte then stop, or tx dma
	i2crts_pkg::bus_action_t                 wr_act;
	i2crts_pkg::phase_t                      wr_phase;
	logic [7:0]                              wr_byte;
	logic [i2crts_pkg::LENGTH_W-1:0]         wr_count;
	logic                                    wr_dma;

	assign busy    = (phase_q != i2crts_pkg::PH_IDLE) || dma_run_q;
	assign req_cnt = (item.register_address_bytes > MaxCnt) ? MaxCnt
		: item.register_address_bytes;
	assign left_dec = (reg_left_q != '0) ? reg_left_q - 1'b1 : reg_left_q;
	assign addr_wr  = {target_q[7:1], 1'b0};
	assign addr_rd  = {target_q[7:1], 1'b1};

	always_comb begin
		case (left_dec[1:0])
			2'd0:    reg_byte = reg_held_q[7:0];
			2'd1:    reg_byte = reg_held_q[15:8];
			2'd2:    reg_byte = reg_held_q[23:16];
			default: reg_byte = reg_held_q[31:24];
		endcase
		// positions past the 32-bit address send zero
		if (left_dec[2]) begin
			reg_byte = 8'd0;
		end
	end

	always_comb begin
		wr_byte  = 8'd0;
		wr_count = '0;
		wr_dma   = 1'b0;
		if (length_q == '0) begin
			wr_act   = i2crts_pkg::ACT_STOP;
			wr_phase = i2crts_pkg::PH_IDLE;
		end else if (length_q == i2crts_pkg::LENGTH_W'(1)) begin
			wr_act   = i2crts_pkg::ACT_DATA;
			wr_byte  = data_byte_q;
			wr_phase = i2crts_pkg::PH_STOP;
		end else begin
			wr_act   = i2crts_pkg::ACT_TX_DMA;
			wr_count = length_q;
			wr_dma   = 1'b1;
			wr_phase = i2crts_pkg::PH_IDLE;
		end
	end

	always_comb begin
		phase_d     = phase_q;
		target_d    = target_q;
		reg_held_d  = reg_held_q;
		reg_left_d  = reg_left_q;
		reg_count_d = reg_count_q;
		is_read_d   = is_read_q;
		length_d    = length_q;
		data_byte_d = data_byte_q;
		dma_run_d   = dma_run_q;

		result.request_status = 1'b0;
		result.bus_action     = i2crts_pkg::ACT_NONE;
		result.bus_byte       = 8'd0;
		result.dma_count      = '0;

		unique case (item.req_type) inside
			i2crts_pkg::REQ_WRITE, i2crts_pkg::REQ_READ: begin
				if (busy) begin
					result.request_status = 1'b1;
				end else begin
					target_d    = item.device_address;
					reg_held_d  = item.register_address;
					reg_count_d = req_cnt;
					reg_left_d  = req_cnt;
					is_read_d   = (item.req_type == i2crts_pkg::REQ_READ);
					length_d    = item.transfer_length;
					data_byte_d = (item.req_type == i2crts_pkg::REQ_WRITE)
						? item.single_data_byte : 8'd0;
					phase_d     = i2crts_pkg::PH_DEV_ADDR;
					result.bus_action = i2crts_pkg::ACT_START;
				end
			end
			i2crts_pkg::REQ_EVENT: begin
				unique case (phase_q)
					i2crts_pkg::PH_IDLE: begin
						phase_d = i2crts_pkg::PH_IDLE;
					end
					i2crts_pkg::PH_DEV_ADDR: begin
						if (item.start_sent) begin
							result.bus_action = i2crts_pkg::ACT_ADDR;
							if (is_read_q && reg_count_q == '0) begin
								result.bus_byte = addr_rd;
								phase_d         = i2crts_pkg::PH_RX_DMA;
							end else begin
								result.bus_byte = addr_wr;
								phase_d = (reg_count_q != '0) ? i2crts_pkg::PH_REG_ADDR
									: i2crts_pkg::PH_DATA_ONLY;
							end
						end
					end
					i2crts_pkg::PH_REG_ADDR: begin
						if (item.address_acked || item.tx_empty) begin
							reg_left_d        = left_dec;
							result.bus_action = i2crts_pkg::ACT_DATA;
							result.bus_byte   = reg_byte;
							if (left_dec == '0) begin
								phase_d = is_read_q ? i2crts_pkg::PH_RESTART
									: i2crts_pkg::PH_REG_DATA;
							end
						end
					end
					i2crts_pkg::PH_DATA_ONLY: begin
						if (item.address_acked) begin
							result.bus_action = wr_act;
							result.bus_byte   = wr_byte;
							result.dma_count  = wr_count;
							phase_d           = wr_phase;
							dma_run_d         = dma_run_q | wr_dma;
						end
					end
					i2crts_pkg::PH_REG_DATA: begin
						if (item.tx_empty) begin
							result.bus_action = wr_act;
							result.bus_byte   = wr_byte;
							result.dma_count  = wr_count;
							phase_d           = wr_phase;
							dma_run_d         = dma_run_q | wr_dma;
						end
					end
					i2crts_pkg::PH_STOP: begin
						if (item.tx_empty || item.byte_finished) begin
							result.bus_action = i2crts_pkg::ACT_STOP;
							phase_d           = i2crts_pkg::PH_IDLE;
						end
					end
					i2crts_pkg::PH_RESTART: begin
						if (item.tx_empty || item.byte_finished) begin
							result.bus_action = i2crts_pkg::ACT_START;
							phase_d           = i2crts_pkg::PH_READ_ADDR;
						end
					end
					i2crts_pkg::PH_READ_ADDR: begin
						if (item.start_sent) begin
							result.bus_action = i2crts_pkg::ACT_ADDR;
							result.bus_byte   = addr_rd;
							phase_d           = i2crts_pkg::PH_RX_DMA;
						end
					end
					i2crts_pkg::PH_RX_DMA: begin
						if (item.address_acked || item.byte_finished) begin
							if (length_q == '0) begin
								result.bus_action = i2crts_pkg::ACT_STOP;
							end else begin
								result.bus_action = i2crts_pkg::ACT_RX_DMA;
								result.dma_count  = length_q;
								dma_run_d         = 1'b1;
							end
							phase_d = i2crts_pkg::PH_IDLE;
						end
					end
					default: begin
						phase_d = i2crts_pkg::PH_IDLE;
					end
				endcase
			end
			default: begin
				if (dma_run_q) begin
					dma_run_d         = 1'b0;
					phase_d           = i2crts_pkg::PH_IDLE;
					result.bus_action = i2crts_pkg::ACT_STOP;
				end
			end
		endcase

		result.busy_now = (phase_d != i2crts_pkg::PH_IDLE) || dma_run_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= i2crts_pkg::PH_IDLE;
			target_q    <= '0;
			reg_held_q  <= '0;
			reg_left_q  <= '0;
			reg_count_q <= '0;
			is_read_q   <= 1'b0;
			length_q    <= '0;
			data_byte_q <= '0;
			dma_run_q   <= 1'b0;
		end else if (advance) begin
			phase_q     <= phase_d;
			target_q    <= target_d;
			reg_held_q  <= reg_held_d;
			reg_left_q  <= reg_left_d;
			reg_count_q <= reg_count_d;
			is_read_q   <= is_read_d;
			length_q    <= length_d;
			data_byte_q <= data_byte_d;
			dma_run_q   <= dma_run_d;
		end
	end

endmodule

`default_nettype wire
